>>> design/assert_macros.svh
// Assertion helpers shared by crr_input and crr_output.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CRR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CRR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/crr_pkg.sv
`default_nettype none

package crr_pkg;

   // Default screen and line buffer geometry
   localparam int SCREEN_WIDTH_DEF  = 480;
   localparam int SCREEN_HEIGHT_DEF = 320;
   localparam int BUFFER_LINES_DEF  = 24;

   // Field and internal widths
   localparam int AREA_W         = 12;
   localparam int COORD_W        = 14;
   localparam int COUNT_W        = 24;
   localparam int PIXEL_W        = 16;
   localparam int SCREEN_COORD_W = 9;
   localparam int CHAN_W         = 8;
   localparam int CSR_INDEX_W    = 2;
   localparam int RSP_FIELDS_W   = 3 * CHAN_W + 2 * SCREEN_COORD_W;
   localparam int RSP_DATA_W     = 48;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_AREA_LEFT   = 2'd0,
      CSR_AREA_TOP    = 2'd1,
      CSR_AREA_RIGHT  = 2'd2,
      CSR_AREA_BOTTOM = 2'd3
   } csr_index_type;

   // Source rectangle corners as written
   typedef struct packed {
      logic signed [AREA_W-1:0] left;
      logic signed [AREA_W-1:0] top;
      logic signed [AREA_W-1:0] right;
      logic signed [AREA_W-1:0] bottom;
   } area_type;

   // Rectangle clipped to the screen; valid when it is shown at all
   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] x_lo;
      logic signed [COORD_W-1:0] x_hi;
      logic signed [COORD_W-1:0] y_lo;
      logic signed [COORD_W-1:0] y_hi;
   } window_type;

   // One accepted pixel with its screen position
   typedef struct packed {
      logic [PIXEL_W-1:0]        pixel;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } stage_type;

endpackage

`default_nettype wire

>>> design/crr_window.sv
`default_nettype none

module crr_window
   import crr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int BUFFER_LINES  = BUFFER_LINES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [AREA_W-1:0]      csr_wdata,
   output area_type                    area,
   output window_type                  window
);

   localparam logic signed [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 1);
   localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);
   localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(SCREEN_WIDTH * BUFFER_LINES);

   area_type   area_ff, area_in;
   window_type window_ff, window_in;

   logic signed [COORD_W-1:0] left_x, top_y, right_x, bottom_y;
   logic signed [COORD_W-1:0] clip_w, clip_h;
   logic [AREA_W-1:0]         clip_w_u, clip_h_u;
   logic [COUNT_W-1:0]        count;
   logic                      on_screen, nonempty;

   // Write the corner registers
   always_comb begin
      area_in = area_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_AREA_LEFT:   area_in.left   = csr_wdata;
            CSR_AREA_TOP:    area_in.top    = csr_wdata;
            CSR_AREA_RIGHT:  area_in.right  = csr_wdata;
            CSR_AREA_BOTTOM: area_in.bottom = csr_wdata;
            default: ;
         endcase
      end
   end

   // Clip the rectangle to the screen and size the result
   always_comb begin
      left_x   = {{(COORD_W-AREA_W){area_ff.left[AREA_W-1]}},   area_ff.left};
      top_y    = {{(COORD_W-AREA_W){area_ff.top[AREA_W-1]}},    area_ff.top};
      right_x  = {{(COORD_W-AREA_W){area_ff.right[AREA_W-1]}},  area_ff.right};
      bottom_y = {{(COORD_W-AREA_W){area_ff.bottom[AREA_W-1]}}, area_ff.bottom};

      on_screen = !(right_x < 0 || bottom_y < 0 || left_x > X_MAX || top_y > Y_MAX);
      nonempty  = (right_x >= left_x) && (bottom_y >= top_y);

      window_in.x_lo = (left_x < 0) ? '0 : left_x;
      window_in.y_lo = (top_y < 0) ? '0 : top_y;
      window_in.x_hi = (right_x > X_MAX) ? X_MAX : right_x;
      window_in.y_hi = (bottom_y > Y_MAX) ? Y_MAX : bottom_y;

      clip_w   = window_in.x_hi - window_in.x_lo + COORD_W'(1);
      clip_h   = window_in.y_hi - window_in.y_lo + COORD_W'(1);
      clip_w_u = clip_w[AREA_W-1:0];
      clip_h_u = clip_h[AREA_W-1:0];
      count    = COUNT_W'(clip_w_u) * COUNT_W'(clip_h_u);

      window_in.valid = on_screen && nonempty && (count <= LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff         <= '0;
         window_ff.valid <= 1'b0;
      end else begin
         area_ff         <= area_in;
         window_ff.valid <= window_in.valid;
      end
      window_ff.x_lo <= window_in.x_lo;
      window_ff.x_hi <= window_in.x_hi;
      window_ff.y_lo <= window_in.y_lo;
      window_ff.y_hi <= window_in.y_hi;
   end

   assign area   = area_ff;
   assign window = window_ff;

endmodule

`default_nettype wire

>>> design/crr_input.sv
`default_nettype none

`include "assert_macros.svh"

module crr_input
   import crr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [PIXEL_W-1:0] req_tdata,
   input  wire area_type           area,
   input  wire logic               csr_we,
   input  wire logic               s_go,
   output logic                    s_valid,
   output stage_type               stage
);

   logic [AREA_W-1:0] col_ff, col_in, row_ff, row_in;
   logic              s_valid_ff, s_valid_in;
   stage_type         stage_ff, stage_in;

   logic signed [COORD_W-1:0] left_x, top_y, right_x, bottom_y;
   logic signed [COORD_W-1:0] src_w, src_h;
   logic [AREA_W:0]           col_next, row_next;
   logic                      nonempty, accept, col_ok, row_ok;

   // Source rectangle size
   always_comb begin
      left_x   = {{(COORD_W-AREA_W){area.left[AREA_W-1]}},   area.left};
      top_y    = {{(COORD_W-AREA_W){area.top[AREA_W-1]}},    area.top};
      right_x  = {{(COORD_W-AREA_W){area.right[AREA_W-1]}},  area.right};
      bottom_y = {{(COORD_W-AREA_W){area.bottom[AREA_W-1]}}, area.bottom};
      src_w    = right_x - left_x + COORD_W'(1);
      src_h    = bottom_y - top_y + COORD_W'(1);
      nonempty = (src_w > 0) && (src_h > 0);
   end

   assign req_tready = !reset && (!s_valid_ff || s_go);
   assign accept     = req_tvalid && req_tready;
   assign col_next   = {1'b0, col_ff} + (AREA_W+1)'(1);
   assign row_next   = {1'b0, row_ff} + (AREA_W+1)'(1);

   // Capture the request and advance the raster counters
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      stage_in   = stage_ff;
      s_valid_in = s_valid_ff && !s_go;
      if (accept) begin
         s_valid_in     = nonempty;
         stage_in.pixel = req_tdata;
         stage_in.x     = left_x + COORD_W'(col_ff);
         stage_in.y     = top_y + COORD_W'(row_ff);
      end
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (!nonempty) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= src_w[AREA_W:0]) begin
            col_in = '0;
            row_in = (row_next >= src_h[AREA_W:0]) ? '0 : row_next[AREA_W-1:0];
         end else begin
            col_in = col_next[AREA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         s_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         s_valid_ff <= s_valid_in;
      end
      stage_ff <= stage_in;
   end

   assign s_valid = s_valid_ff;
   assign stage   = stage_ff;

   // Counters stay inside the rectangle and rest at zero when it is empty
   assign col_ok = {1'b0, col_ff} < src_w[AREA_W:0];
   assign row_ok = {1'b0, row_ff} < src_h[AREA_W:0];

   `CRR_ASSERT_IMP(a_counters_in_rect, clock, reset, nonempty, col_ok && row_ok)
   `CRR_ASSERT_IMP(a_counters_idle_empty, clock, reset, !nonempty, col_ff == '0 && row_ff == '0)

endmodule

`default_nettype wire

>>> design/crr_output.sv
`default_nettype none

`include "assert_macros.svh"

module crr_output
   import crr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire window_type            window,
   input  wire logic                  s_valid,
   input  wire stage_type             stage,
   output logic                       s_go,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   logic                    out_valid_ff, out_valid_in;
   logic [RSP_FIELDS_W-1:0] data_ff, data_in;
   logic                    last_ff, last_in;
   logic                    hit, out_free, load;
   logic [CHAN_W-1:0]       red, green, blue;

   // Widen a 5-bit channel to 6 bits and place it in bits 7..2
   function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
      return {v, v[4], 2'b00};
   endfunction

   // Test the pixel against the clipped window
   assign hit = window.valid &&
                stage.x >= window.x_lo && stage.x <= window.x_hi &&
                stage.y >= window.y_lo && stage.y <= window.y_hi;

   assign out_free = !out_valid_ff || rsp_tready;
   assign s_go     = s_valid && (out_free || !hit);
   assign load     = s_valid && hit && out_free;

   // Convert the color and pack the result
   always_comb begin
      red          = widen5(stage.pixel[15:11]);
      green        = {stage.pixel[10:5], 2'b00};
      blue         = widen5(stage.pixel[4:0]);
      data_in      = data_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (load) begin
         out_valid_in = 1'b1;
         data_in      = {stage.y[SCREEN_COORD_W-1:0], stage.x[SCREEN_COORD_W-1:0],
                         blue, green, red};
         last_in      = (stage.x == window.x_hi) && (stage.y == window.y_hi);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-RSP_FIELDS_W)'(0), data_ff};
   assign rsp_tlast  = last_ff;

   // A pixel outside the window never raises a response
   `CRR_ASSERT_NEXT(a_miss_no_rsp, clock, reset, s_valid && !hit && !out_valid_ff, !out_valid_ff)
   // A loaded pixel shows up in the output register
   `CRR_ASSERT_NEXT(a_load_shown, clock, reset, load, out_valid_ff && data_ff == $past(data_in))

endmodule

`default_nettype wire

>>> design/clip_rgb565_to_rgb666_stream.sv
// Clips a signed source rectangle to the screen and converts its RGB565 pixels,
// taken in raster order, to RGB666 bytes with their screen coordinates. Set the
// four corner registers while the stream is idle; any write restarts the raster
// counters. Throughput is one pixel per clock while responses are taken. From
// request to response, an input stage holds the pixel and its position, and an
// output register holds the response. While a response waits, the input stage
// takes one more request and then stalls on a pixel inside the window; pixels
// outside it keep draining. Pixels outside the clipped window, or of a rectangle
// that is off screen, empty or larger than SCREEN_WIDTH * BUFFER_LINES pixels
// after clipping, are consumed without a response. The clip limits are
// registered from the corner registers that a write updates.
`default_nettype none

module clip_rgb565_to_rgb666_stream
   import crr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int BUFFER_LINES  = BUFFER_LINES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [PIXEL_W-1:0]     req_tdata,   // pixel_rgb565[15:0]
   // Response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // red_byte[7:0], green_byte[15:8],
                                                    // blue_byte[23:16], screen_x[32:24],
                                                    // screen_y[41:33], zero[47:42]
   output logic                        rsp_tlast,   // last_pixel
   // Register write port
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [AREA_W-1:0]      csr_wdata
);

   area_type   area;
   window_type window;
   stage_type  stage;
   logic       s_valid, s_go;

   crr_window #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .BUFFER_LINES  (BUFFER_LINES)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .area      (area),
      .window    (window)
   );

   crr_input u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .area       (area),
      .csr_we     (csr_we),
      .s_go       (s_go),
      .s_valid    (s_valid),
      .stage      (stage)
   );

   crr_output u_output (
      .clock      (clock),
      .reset      (reset),
      .window     (window),
      .s_valid    (s_valid),
      .stage      (stage),
      .s_go       (s_go),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
